// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/ptpq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpq_pkg
// Types and constants of the PTP lock qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpq_pkg;

  localparam int SETTLE_W = 47;
  localparam int UTC_W    = 10;
  localparam int UTC_NS_W = 40;

  localparam logic [UTC_NS_W-1:0] NS_PER_SEC = 40'd1000000000;

  localparam logic [SETTLE_W-1:0] SETTLE_RST = 47'd5000000000;
  localparam logic [UTC_W-1:0]    UTC_RST    = 10'd37;
  localparam logic [UTC_NS_W-1:0] UTC_NS_RST = 40'd37000000000;

  localparam logic [2:0] ST_NOPORT     = 3'd0;
  localparam logic [2:0] ST_NOTCAPABLE = 3'd1;
  localparam logic [2:0] ST_OWNGM      = 3'd2;
  localparam logic [2:0] ST_NOLOCK     = 3'd3;
  localparam logic [2:0] ST_NOTPTP     = 3'd4;
  localparam logic [2:0] ST_SETTLE     = 3'd5;
  localparam logic [2:0] ST_LOCK       = 3'd6;

  typedef struct packed {
    logic               port_exists;
    logic               port_usable;
    logic [63:0]        own_clock_id;
    logic [63:0]        domain_gm_id;
    logic               domain_locked;
    logic               conversion_ptp_valid;
    logic [63:0]        conversion_gm_id;
    logic               disturbed;
    logic [63:0]        sample_time_ns;
    logic signed [63:0] gptp_time_ns;
    logic signed [63:0] system_time_ns;
    logic               bracket_good;
  } sample_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               state_changed;
    logic               resettled;
    logic               send_sample;
    logic signed [63:0] clock_skew_ns;
  } result_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_time_ns;
    logic [UTC_NS_W-1:0] utc_shift_ns;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/ptpq_regs.sv =====
// ----------------------------------------------------------------------------
// ptpq_regs
// APB register file: settle time and UTC offset, offset kept in ns as well.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpq_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  output ptpq_pkg::cfg_t          cfg
);

  logic [ptpq_pkg::SETTLE_W-1:0] settle_time;
  logic [ptpq_pkg::UTC_W-1:0]    utc_s;
  logic [ptpq_pkg::UTC_NS_W-1:0] utc_ns;
  logic [ptpq_pkg::UTC_NS_W-1:0] utc_ns_next;
  logic                          wr;

  assign pready      = 1'b1;
  assign wr          = psel && penable && pwrite;
  assign utc_ns_next = ptpq_pkg::UTC_NS_W'(pwdata[ptpq_pkg::UTC_W-1:0]) * ptpq_pkg::NS_PER_SEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_time <= ptpq_pkg::SETTLE_RST;
      utc_s       <= ptpq_pkg::UTC_RST;
      utc_ns      <= ptpq_pkg::UTC_NS_RST;
    end else if (wr) begin
      if (paddr[3]) begin
        utc_s  <= pwdata[ptpq_pkg::UTC_W-1:0];
        utc_ns <= utc_ns_next;
      end else begin
        settle_time <= pwdata[ptpq_pkg::SETTLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3]) begin
      prdata = 64'(utc_s);
    end else begin
      prdata = 64'(settle_time);
    end
  end

  assign cfg.settle_time_ns = settle_time;
  assign cfg.utc_shift_ns   = utc_ns;

endmodule

`default_nettype wire

// ===== src/ptp_lock_qualifier.sv =====
// ----------------------------------------------------------------------------
// ptp_lock_qualifier
// Classifies timing samples, runs the settle timer and gates sending.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_ready  ptpq_pkg::sample_t
//  result    out        result_valid / result_ready  ptpq_pkg::result_t
//  apb       in         psel / penable / pready      64-bit regs at 0x0, 0x8
//
//  One item per cycle sustained while results are taken; path is input reg, then result reg.
//  Classifier, settle compare and offset subtract sit between the two regs.
//  Stalled result holds; the input reg still takes one item, then the
//  input stalls until the result is taken.
//  Synchronous reset clears state, valids and config regs to defaults; data regs are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptp_lock_qualifier (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire ptpq_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output ptpq_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  ptpq_pkg::cfg_t    cfg;
  ptpq_pkg::sample_t smp;
  logic              smp_valid;
  ptpq_pkg::result_t res_next;

  logic [2:0]  cur_status;
  logic [2:0]  cur_status_next;
  logic        status_seen;
  logic [63:0] settle_start;
  logic [63:0] settle_start_next;
  logic [63:0] lock_gm;
  logic [63:0] lock_gm_next;

  logic        advance;
  logic        fire;
  logic        restart;
  logic        reached;
  logic [63:0] elapsed;

  ptpq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance      = !result_valid || result_ready;
  assign sample_ready = !smp_valid || advance;
  assign fire         = smp_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      smp <= sample;
    end
  end

  assign elapsed = smp.sample_time_ns - settle_start;
  assign restart = smp.disturbed || (lock_gm != smp.domain_gm_id) ||
                   (cur_status < ptpq_pkg::ST_SETTLE);
  // negative elapsed never locks
  assign reached = !elapsed[63] &&
                   ((elapsed[62:ptpq_pkg::SETTLE_W] != '0) ||
                    (elapsed[ptpq_pkg::SETTLE_W-1:0] >= cfg.settle_time_ns));

  always_comb begin
    cur_status_next   = ptpq_pkg::ST_NOPORT;
    settle_start_next = settle_start;
    lock_gm_next      = lock_gm;
    res_next.resettled = 1'b0;
    if (!smp.port_exists) begin
      cur_status_next = ptpq_pkg::ST_NOPORT;
    end else if (!smp.port_usable) begin
      cur_status_next = ptpq_pkg::ST_NOTCAPABLE;
    end else if (smp.domain_gm_id == smp.own_clock_id) begin
      cur_status_next = ptpq_pkg::ST_OWNGM;
    end else if (!smp.domain_locked) begin
      cur_status_next = ptpq_pkg::ST_NOLOCK;
    end else if (!smp.conversion_ptp_valid || (smp.conversion_gm_id != smp.domain_gm_id)) begin
      cur_status_next = ptpq_pkg::ST_NOTPTP;
    end else if (restart) begin
      settle_start_next  = smp.sample_time_ns;
      lock_gm_next       = smp.domain_gm_id;
      res_next.resettled = smp.disturbed && (cur_status == ptpq_pkg::ST_LOCK);
      cur_status_next    = (cfg.settle_time_ns == '0) ? ptpq_pkg::ST_LOCK
                                                      : ptpq_pkg::ST_SETTLE;
    end else begin
      cur_status_next = reached ? ptpq_pkg::ST_LOCK : ptpq_pkg::ST_SETTLE;
    end
    res_next.status        = cur_status_next;
    res_next.state_changed = !status_seen || (cur_status_next != cur_status);
    res_next.send_sample   = (cur_status_next == ptpq_pkg::ST_LOCK) && smp.bracket_good;
    res_next.clock_skew_ns = smp.gptp_time_ns - 64'(cfg.utc_shift_ns) - smp.system_time_ns;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      cur_status   <= ptpq_pkg::ST_NOPORT;
      status_seen  <= 1'b0;
      settle_start <= '0;
      lock_gm      <= '0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
        cur_status   <= cur_status_next;
        status_seen  <= 1'b1;
        settle_start <= settle_start_next;
        lock_gm      <= lock_gm_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  `ASSERT_RST(a_send_locked, clk, rst, result_valid |-> (!result.send_sample || result.status == ptpq_pkg::ST_LOCK))
  `ASSERT_RST(a_resettle_settle, clk, rst, (result_valid && result.resettled) |-> (result.status >= ptpq_pkg::ST_SETTLE))
  `ASSERT_RST(a_status_tracks, clk, rst, result_valid |-> (cur_status == result.status))
  `ASSERT_ALWAYS(a_seen_first, clk, !status_seen |-> !result_valid)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for ptp_lock_qualifier. Each timing sample is classified,
// timed against the settle window and scored against an internal model of
// the qualifier. The sender works in bursts, the receiver stalls at random,
// and the two registers are rewritten between phases over a range of
// settle times and UTC offsets.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [3:0] ADDR_SETTLE = 4'h0;
  localparam logic [3:0] ADDR_UTC    = 4'h8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 175;
  localparam logic [63:0] GM_A  = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] GM_B  = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] OWN_D = 64'h5a5a_0000_ffff_a5a5;

  class lock_scoreboard;
    logic [ptpq_pkg::SETTLE_W-1:0] settle_ns;
    logic [ptpq_pkg::UTC_W-1:0]    utc_s;
    logic [2:0]                    last_status;
    bit                            seen;
    logic [63:0]                   timer_start;
    logic [63:0]                   timer_gm;
    ptpq_pkg::result_t             results_due[$];
    int                            errors;
    int                            checked;
    int                            status_hits[8];
    int                            resettles;
    int                            sends;

    function new();
      settle_ns   = ptpq_pkg::SETTLE_RST;
      utc_s       = ptpq_pkg::UTC_RST;
      last_status = ptpq_pkg::ST_NOPORT;
      seen        = 0;
      timer_start = '0;
      timer_gm    = '0;
      errors      = 0;
      checked     = 0;
      resettles   = 0;
      sends       = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [63:0] data);
      case (addr)
        ADDR_SETTLE: settle_ns = data[ptpq_pkg::SETTLE_W-1:0];
        ADDR_UTC:    utc_s = data[ptpq_pkg::UTC_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void qualify_sample(ptpq_pkg::sample_t s);
      logic [2:0]        st;
      bit                restarted;
      logic [63:0]       elapsed;
      logic [63:0]       utc_ns;
      logic [63:0]       gptp;
      logic [63:0]       sys;
      ptpq_pkg::result_t want;
      restarted = 0;
      if (!s.port_exists) st = ptpq_pkg::ST_NOPORT;
      else if (!s.port_usable) st = ptpq_pkg::ST_NOTCAPABLE;
      else if (s.domain_gm_id == s.own_clock_id) st = ptpq_pkg::ST_OWNGM;
      else if (!s.domain_locked) st = ptpq_pkg::ST_NOLOCK;
      else if (!s.conversion_ptp_valid || s.conversion_gm_id != s.domain_gm_id)
        st = ptpq_pkg::ST_NOTPTP;
      else begin
        if (s.disturbed || timer_gm != s.domain_gm_id ||
            last_status < ptpq_pkg::ST_SETTLE) begin
          timer_start = s.sample_time_ns;
          timer_gm    = s.domain_gm_id;
          restarted   = s.disturbed && last_status == ptpq_pkg::ST_LOCK;
        end
        elapsed = s.sample_time_ns - timer_start;
        st = (!elapsed[63] && elapsed >= {17'd0, settle_ns}) ? ptpq_pkg::ST_LOCK
                                                             : ptpq_pkg::ST_SETTLE;
      end
      utc_ns = {54'd0, utc_s} * 64'd1000000000;
      gptp   = s.gptp_time_ns;
      sys    = s.system_time_ns;
      want.status        = st;
      want.state_changed = !seen || st != last_status;
      want.resettled     = restarted;
      want.send_sample   = st == ptpq_pkg::ST_LOCK && s.bracket_good;
      want.clock_skew_ns = gptp - utc_ns - sys;
      last_status = st;
      seen        = 1;
      status_hits[st]++;
      if (restarted) resettles++;
      if (want.send_sample) sends++;
      results_due.push_back(want);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] result %0d: %s got %h, want %h", $time, checked, field, got, want);
    endtask

    task compare_result(ptpq_pkg::result_t r);
      ptpq_pkg::result_t want;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected item", r.clock_skew_ns, '0);
        return;
      end
      want = results_due.pop_front();
      if (r.status !== want.status)
        report_mismatch("status", 64'(r.status), 64'(want.status));
      if (r.state_changed !== want.state_changed)
        report_mismatch("state_changed", 64'(r.state_changed), 64'(want.state_changed));
      if (r.resettled !== want.resettled)
        report_mismatch("resettled", 64'(r.resettled), 64'(want.resettled));
      if (r.send_sample !== want.send_sample)
        report_mismatch("send_sample", 64'(r.send_sample), 64'(want.send_sample));
      if (r.clock_skew_ns !== want.clock_skew_ns)
        report_mismatch("clock_skew_ns", r.clock_skew_ns, want.clock_skew_ns);
      checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  ptpq_pkg::sample_t sample = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  ptpq_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;

  lock_scoreboard sb = new();

  int unsigned cycles = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          rx_tick = 0;
  int          burst_left = 0;
  int          n_settings = 0;
  logic [63:0] t_now;
  logic [63:0] step_max;
  logic [63:0] own_id;
  logic [63:0] gm_pool[4];
  int          cur_gm;

  ptp_lock_qualifier dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still due", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall modes plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.compare_result(result);
    if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = 80;
    end
    if (rx_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        2: result_ready <= (rx_tick % 7) >= 3;
        default: result_ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] lim);
    if (&lim) return rand64();
    return rand64() % (lim + 64'd1);
  endfunction

  function automatic ptpq_pkg::sample_t good_at(logic [63:0] t);
    ptpq_pkg::sample_t s;
    s.port_exists          = 1'b1;
    s.port_usable          = 1'b1;
    s.own_clock_id         = OWN_D;
    s.domain_gm_id         = GM_A;
    s.domain_locked        = 1'b1;
    s.conversion_ptp_valid = 1'b1;
    s.conversion_gm_id     = GM_A;
    s.disturbed            = 1'b0;
    s.sample_time_ns       = t;
    s.gptp_time_ns         = rand64();
    s.system_time_ns       = rand64();
    s.bracket_good         = 1'b1;
    return s;
  endfunction

  // mostly clean lock sequences, some broken conditions, a little noise
  function automatic ptpq_pkg::sample_t make_sample();
    ptpq_pkg::sample_t s;
    if ($urandom_range(0, 99) < 3) t_now = t_now - rand_upto(step_max);
    else t_now = t_now + rand_upto(step_max);
    if ($urandom_range(0, 24) == 0) cur_gm = $urandom_range(0, 3);
    s = good_at(t_now);
    s.own_clock_id     = own_id;
    s.domain_gm_id     = gm_pool[cur_gm];
    s.conversion_gm_id = gm_pool[cur_gm];
    s.disturbed        = $urandom_range(0, 19) == 0;
    s.bracket_good     = $urandom_range(0, 7) != 0;
    if ($urandom_range(0, 99) < 5) begin
      s.port_exists          = 1'($urandom);
      s.port_usable          = 1'($urandom);
      s.own_clock_id         = rand64();
      s.domain_gm_id         = rand64();
      s.domain_locked        = 1'($urandom);
      s.conversion_ptp_valid = 1'($urandom);
      s.conversion_gm_id     = rand64();
      s.disturbed            = 1'($urandom);
      s.sample_time_ns       = rand64();
      s.bracket_good         = 1'($urandom);
    end else if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 5))
        0: s.port_exists = 1'b0;
        1: s.port_usable = 1'b0;
        2: s.own_clock_id = s.domain_gm_id;
        3: s.domain_locked = 1'b0;
        4: s.conversion_ptp_valid = 1'b0;
        default: s.conversion_gm_id = s.domain_gm_id ^ (64'd1 << $urandom_range(0, 63));
      endcase
    end
    return s;
  endfunction

  task automatic send_sample(input ptpq_pkg::sample_t s, input bit last);
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    sb.qualify_sample(s);
    if (last) sample_valid <= 1'b0;
    else if (burst_left > 0) burst_left--;
    else begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [63:0] settle_w, input logic [63:0] utc_w,
                           input logic [63:0] t_start, input logic [63:0] step,
                           input bit squeeze, input bit pause_mid);
    wait_drain();
    apb_write(ADDR_SETTLE, settle_w);
    apb_write(ADDR_UTC, utc_w);
    n_settings++;
    t_now    = t_start;
    step_max = step;
    own_id   = rand64();
    foreach (gm_pool[k]) gm_pool[k] = rand64();
    cur_gm = 0;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (squeeze && i == 30) begin
        hold_reqs <= hold_reqs + 1;
        burst_left = 60;
      end
      if (pause_mid && i == ITEMS_PER_PHASE / 2) wait_drain();
      send_sample(make_sample(),
                  i == ITEMS_PER_PHASE - 1 || (pause_mid && i == ITEMS_PER_PHASE / 2 - 1));
    end
  endtask

  initial begin
    ptpq_pkg::sample_t s;
    logic [63:0]       t0;
    logic [63:0]       t1;
    logic [63:0]       settle_r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: every status, lock and resettle, backwards time, extremes
    t0 = 64'd1000000000000;
    t1 = t0 + 64'(ptpq_pkg::SETTLE_RST) + 64'd20;
    s = '0;
    send_sample(s, 0);
    s = '0;
    s.gptp_time_ns   = 64'h7fff_ffff_ffff_ffff;
    s.system_time_ns = 64'h8000_0000_0000_0000;
    send_sample(s, 0);
    s = '0;
    s.port_exists = 1'b1;
    send_sample(s, 0);
    s = good_at(t0);
    s.own_clock_id = '0;
    s.domain_gm_id = '0;
    send_sample(s, 0);
    s = good_at(t0);
    s.own_clock_id     = '1;
    s.domain_gm_id     = '1;
    s.conversion_gm_id = '1;
    send_sample(s, 0);
    s = good_at(t0);
    s.domain_locked = 1'b0;
    send_sample(s, 0);
    s = good_at(t0);
    s.conversion_ptp_valid = 1'b0;
    send_sample(s, 0);
    s = good_at(t0);
    s.conversion_gm_id = GM_B;
    send_sample(s, 0);
    send_sample(good_at(t0), 0);
    send_sample(good_at(t0 + 64'(ptpq_pkg::SETTLE_RST) - 64'd1), 0);
    send_sample(good_at(t0 + 64'(ptpq_pkg::SETTLE_RST)), 0);
    s = good_at(t0 + 64'(ptpq_pkg::SETTLE_RST) + 64'd10);
    s.bracket_good = 1'b0;
    send_sample(s, 0);
    s = good_at(t1);
    s.disturbed = 1'b1;
    send_sample(s, 0);
    send_sample(good_at(t1 - 64'd1), 0);
    send_sample(good_at(t1 + 64'(ptpq_pkg::SETTLE_RST)), 0);
    s = good_at(t1 + 64'(ptpq_pkg::SETTLE_RST) + 64'd5);
    s.domain_gm_id     = GM_B;
    s.conversion_gm_id = GM_B;
    send_sample(s, 0);
    s = good_at(t1 + 64'(ptpq_pkg::SETTLE_RST) + 64'd6);
    s.domain_gm_id     = GM_B;
    s.conversion_gm_id = GM_B;
    s.disturbed        = 1'b1;
    send_sample(s, 0);
    s = good_at('1);
    s.gptp_time_ns   = 64'h8000_0000_0000_0000;
    s.system_time_ns = 64'h7fff_ffff_ffff_ffff;
    send_sample(s, 1);

    run_phase(64'd5000000000, 64'd37, rand64(), 64'd2500000000, 0, 0);
    run_phase(64'd0, 64'd0, rand64(), 64'd1000, 0, 0);
    run_phase('1, '1, rand64(), 64'h4000_0000_0000, 0, 0);
    run_phase(64'd86400000000000, 64'd1000, rand64(), 64'd43200000000000, 0, 0);
    run_phase(64'd1000, 64'd37, rand64(), 64'd500, 1, 0);
    settle_r = 64'($urandom_range(1, 5000));
    run_phase(settle_r, rand64(), rand64(), settle_r / 2 + 64'd1, 0, 1);
    run_phase(64'd5000000000, 64'd37, 64'hffff_fffe_0000_0000, 64'd2500000000, 0, 0);
    settle_r = rand64();
    run_phase(settle_r, rand64(), rand64(), '1, 0, 0);
    run_phase(64'd1, 64'd1, rand64(), 64'd3, 1, 0);

    wait_drain();
    repeat (10) @(posedge clk);
    $display("%0d samples scored over reset values and %0d register settings", sb.checked,
             n_settings);
    $display("status counts %0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d resettles, %0d sends",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
             sb.status_hits[4], sb.status_hits[5], sb.status_hits[6], sb.resettles, sb.sends);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/ptpq_pkg.sv
src/ptpq_regs.sv
src/ptp_lock_qualifier.sv
dv/tb.sv
